@@ rtl/core/okrt_pkg.sv @@
`default_nettype none

package okrt_pkg;

    // Table geometry.
    localparam int CAPACITY    = 32;
    localparam int DATA_BITS   = 32;
    localparam int MAX_RESULTS = 32;

    // Field widths of the request and result items.
    localparam int OP_W    = 3;
    localparam int KEY_W   = 32;
    localparam int REC_W   = 32;
    localparam int ARG_W   = 6;
    localparam int STAT_W  = 2;
    localparam int ENTR_W  = 6;

    // Record count, able to hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Common width for comparing a count argument against the record count.
    localparam int CMP_W = (CNT_W > ARG_W) ? CNT_W : ARG_W;

    // Stream widths, padded to whole bytes.
    localparam int S_BITS = OP_W + KEY_W + REC_W + ARG_W;
    localparam int S_DATA_W = ((S_BITS + 7) / 8) * 8;
    localparam int M_BITS = STAT_W + KEY_W + REC_W + ENTR_W;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUT    = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
    localparam logic [OP_W-1:0] OP_RETAIN = 3'd3;
    localparam logic [OP_W-1:0] OP_COPY   = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [DATA_BITS-1:0] rec_t;
    typedef logic [CNT_W-1:0]     cnt_t;

endpackage

`default_nettype wire

@@ rtl/core/okrt_cell.sv @@
`default_nettype none

// One storage cell of the record chain. On a shift it takes the record of
// its neighbor toward the tail.
module okrt_cell
    import okrt_pkg::*;
(
    input  wire logic aclk,
    input  wire logic shift_en,
    input  wire key_t key_in,
    input  wire rec_t data_in,
    output key_t      key_out,
    output rec_t      data_out
);

    key_t key_reg;
    rec_t data_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            key_reg  <= key_in;
            data_reg <= data_in;
        end
    end

    assign key_out  = key_reg;
    assign data_out = data_reg;

endmodule

`default_nettype wire

@@ rtl/core/ordered_keyed_record_table.sv @@
// Insertion-ordered keyed record table.
// The slave channel (s_tvalid/s_tready/s_tdata) takes one request per item:
// put, delete, clear, retain newest N, or copy newest N. The master channel
// (m_tvalid/m_tready/m_tdata/m_tuser/m_tlast) returns the results; m_tuser
// marks a result that carries a copied record and m_tlast marks the final
// result of a request. Every request yields at least one result.
// Put, delete, retain and copy step the record chain once per cycle while
// not stalled; a put, delete or copy takes CAPACITY shift steps (a full turn
// of the ring), and a retain takes as many steps as records it drops. Put,
// delete and retain then give one result; clear, bad and no-op requests go
// straight from the accept to their result.
// One request is worked on at a time; s_tready is high only while idle.
// A result waits in the output register while the receiver stalls; during a
// copy run the chain halts on any cycle where the output register is not
// free, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the table and drops any pending
// result; the stored keys and payloads themselves are not cleared.
`default_nettype none

module ordered_keyed_record_table
    import okrt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // s_tdata, from bit 0 up: opcode, key, record_data, count_arg, zero fill.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // m_tdata, from bit 0 up: status, out_key, out_data, entries_now.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,
    // m_tuser: out_valid.
    output logic                      m_tuser,
    // m_tlast: last_of_run.
    output logic                      m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    // Request field unpacking.
    logic [OP_W-1:0]  in_op;
    key_t             in_key;
    logic [REC_W-1:0] in_rec;
    logic [ARG_W-1:0] in_arg;

    assign in_op  = s_tdata[OP_W-1:0];
    assign in_key = s_tdata[OP_W +: KEY_W];
    assign in_rec = s_tdata[OP_W + KEY_W +: REC_W];
    assign in_arg = s_tdata[OP_W + KEY_W + REC_W +: ARG_W];

    state_t           state_reg, state_next;
    logic [OP_W-1:0]  op_reg, op_next;
    key_t             key_reg, key_next;
    rec_t             rec_reg, rec_next;
    logic [ARG_W-1:0] arg_reg, arg_next;
    logic             bad_reg, bad_next;
    logic             found_reg, found_next;
    cnt_t             count_reg, count_next;
    cnt_t             idx_reg, idx_next;
    cnt_t             limit_reg, limit_next;
    cnt_t             skip_reg, skip_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]     out_stat_reg, out_stat_next;
    logic                  out_flag_reg, out_flag_next;
    key_t                  out_key_reg, out_key_next;
    logic [REC_W-1:0]      out_data_reg, out_data_next;
    logic [ENTR_W-1:0]     out_entr_reg, out_entr_next;
    logic                  out_last_reg, out_last_next;

    // The record chain: cell 0 holds the oldest record.
    key_t cell_key  [CAPACITY];
    rec_t cell_data [CAPACITY];
    key_t feed_key;
    rec_t feed_data;
    key_t tap1_key;
    rec_t tap1_data;
    logic shift_en;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == CAPACITY - 1) begin : g_tail
                okrt_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (shift_en),
                    .key_in   (feed_key),
                    .data_in  (feed_data),
                    .key_out  (cell_key[gi]),
                    .data_out (cell_data[gi])
                );
            end else begin : g_body
                okrt_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (shift_en),
                    .key_in   (cell_key[gi+1]),
                    .data_in  (cell_data[gi+1]),
                    .key_out  (cell_key[gi]),
                    .data_out (cell_data[gi])
                );
            end
        end
        // The delete path reads the record behind the head.
        if (CAPACITY > 1) begin : g_tap
            assign tap1_key  = cell_key[1];
            assign tap1_data = cell_data[1];
        end else begin : g_notap
            assign tap1_key  = cell_key[0];
            assign tap1_data = cell_data[0];
        end
    endgenerate

    // Output register is free when empty or being drained this cycle.
    logic out_free;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Decode of the incoming request.
    logic             in_is_valid_op;
    logic             in_bad;
    logic [CMP_W-1:0] in_arg_w;
    logic [CMP_W-1:0] count_w;
    logic [CMP_W-1:0] copy_cnt;
    logic [CMP_W-1:0] copy_cap;

    always_comb begin
        in_is_valid_op = (in_op == OP_PUT) || (in_op == OP_DELETE) ||
                         (in_op == OP_CLEAR) || (in_op == OP_RETAIN) ||
                         (in_op == OP_COPY);
        in_bad = !in_is_valid_op ||
                 (((in_op == OP_PUT) || (in_op == OP_DELETE)) && (in_key == '0));
        in_arg_w = CMP_W'(in_arg);
        count_w  = CMP_W'(count_reg);
        copy_cap = CMP_W'(MAX_RESULTS);
        copy_cnt = (count_w < in_arg_w) ? count_w : in_arg_w;
        if (copy_cnt > copy_cap) begin
            copy_cnt = copy_cap;
        end
    end

    // Per-step decisions while the chain turns.
    logic in_range;
    logic match;
    logic last_step;
    logic emit;
    cnt_t idx_inc;

    always_comb begin
        idx_inc   = idx_reg + cnt_t'(1);
        in_range  = (idx_reg < count_reg);
        match     = in_range && !found_reg && (cell_key[0] == key_reg);
        last_step = (idx_inc == limit_reg);
        emit      = (op_reg == OP_COPY) && (idx_reg >= skip_reg) && in_range;
    end

    // Final status and record count of a request that ends in one result.
    logic [STAT_W-1:0] fin_stat;
    cnt_t              fin_count;

    always_comb begin
        fin_stat  = ST_OK;
        fin_count = count_reg;
        if (bad_reg) begin
            fin_stat = ST_BAD;
        end else begin
            unique case (op_reg)
                OP_PUT: begin
                    if (!found_reg) begin
                        if (count_reg < cnt_t'(CAPACITY)) begin
                            fin_count = count_reg + cnt_t'(1);
                        end else begin
                            fin_stat = ST_FULL;
                        end
                    end
                end
                OP_DELETE: begin
                    if (found_reg) begin
                        fin_count = count_reg - cnt_t'(1);
                    end
                end
                OP_CLEAR: begin
                    fin_count = '0;
                end
                OP_RETAIN: begin
                    if (CMP_W'(arg_reg) < CMP_W'(count_reg)) begin
                        fin_count = cnt_t'(arg_reg);
                    end
                end
                default: begin
                    fin_count = count_reg;
                end
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        rec_next       = rec_reg;
        arg_next       = arg_reg;
        bad_next       = bad_reg;
        found_next     = found_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        limit_next     = limit_reg;
        skip_next      = skip_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_stat_next  = out_stat_reg;
        out_flag_next  = out_flag_reg;
        out_key_next   = out_key_reg;
        out_data_next  = out_data_reg;
        out_entr_next  = out_entr_reg;
        out_last_next  = out_last_reg;
        shift_en       = 1'b0;
        feed_key       = cell_key[0];
        feed_data      = cell_data[0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = in_op;
                    key_next   = in_key;
                    rec_next   = rec_t'(in_rec);
                    arg_next   = in_arg;
                    bad_next   = in_bad;
                    found_next = 1'b0;
                    idx_next   = '0;
                    limit_next = cnt_t'(CAPACITY);
                    skip_next  = count_reg - cnt_t'(copy_cnt);
                    state_next = S_DONE;
                    if (!in_bad) begin
                        if ((in_op == OP_PUT) || (in_op == OP_DELETE)) begin
                            state_next = S_RUN;
                        end else if ((in_op == OP_RETAIN) && (in_arg_w < count_w)) begin
                            // Turning the ring by the dropped count leaves
                            // the newest records at the head.
                            limit_next = count_reg - cnt_t'(in_arg);
                            state_next = S_RUN;
                        end else if ((in_op == OP_COPY) && (copy_cnt != '0)) begin
                            state_next = S_RUN;
                        end
                    end
                end
            end

            S_RUN: begin
                // A copy step waits until the output register is free.
                if ((op_reg != OP_COPY) || out_free) begin
                    shift_en = 1'b1;
                    idx_next = idx_inc;
                    if (op_reg == OP_PUT) begin
                        if (match || (!found_reg && (idx_reg == count_reg))) begin
                            feed_key  = key_reg;
                            feed_data = rec_reg;
                        end
                        found_next = found_reg || match;
                    end else if (op_reg == OP_DELETE) begin
                        // From the match on, each record moves up one place.
                        if (match || found_reg) begin
                            feed_key  = tap1_key;
                            feed_data = tap1_data;
                        end
                        found_next = found_reg || match;
                    end
                    if (emit) begin
                        out_valid_next = 1'b1;
                        out_stat_next  = ST_OK;
                        out_flag_next  = 1'b1;
                        out_key_next   = cell_key[0];
                        out_data_next  = REC_W'(cell_data[0]);
                        out_entr_next  = ENTR_W'(count_reg);
                        out_last_next  = (idx_inc == count_reg);
                    end
                    if (last_step) begin
                        state_next = (op_reg == OP_COPY) ? S_IDLE : S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_stat_next  = fin_stat;
                    out_flag_next  = 1'b0;
                    out_key_next   = '0;
                    out_data_next  = '0;
                    out_entr_next  = ENTR_W'(fin_count);
                    out_last_next  = 1'b1;
                    count_next     = fin_count;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            bad_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            bad_reg       <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        rec_reg      <= rec_next;
        arg_reg      <= arg_next;
        idx_reg      <= idx_next;
        limit_reg    <= limit_next;
        skip_reg     <= skip_next;
        out_stat_reg <= out_stat_next;
        out_flag_reg <= out_flag_next;
        out_key_reg  <= out_key_next;
        out_data_reg <= out_data_next;
        out_entr_reg <= out_entr_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_flag_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_DATA_W'({out_entr_reg, out_data_reg, out_key_reg, out_stat_reg});

endmodule

`default_nettype wire
